[hdl/lco_pkg.sv]
// lco_pkg: shared codes, controller states and the outcode function for the
// line clipper. No dependencies.
package lco_pkg;

  // outcode bit positions
  localparam int unsigned BIT_LEFT   = 0;
  localparam int unsigned BIT_RIGHT  = 1;
  localparam int unsigned BIT_BOTTOM = 2;
  localparam int unsigned BIT_TOP    = 3;

  localparam logic [2:0] MAX_PASSES = 3'd4;

  // configuration register indices
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_CODE
  } back_state_t;

  // control from the back-end sequencer to its datapath
  typedef struct packed {
    logic pop;
    logic load_edge;
    logic load_prod;
    logic div_start;
    logic write_point;
    logic write_code;
    logic load_out;
  } back_ctrl_t;

  // coordinates arrive sign-extended to 32 bits
  function automatic logic [3:0] outcode(
    input logic signed [31:0] x,
    input logic signed [31:0] y,
    input logic signed [31:0] lft,
    input logic signed [31:0] rgt,
    input logic signed [31:0] bot,
    input logic signed [31:0] tp
  );
    logic [3:0] c;
    c = 4'd0;
    if (x < lft) begin
      c[BIT_LEFT] = 1'b1;
    end else if (x > rgt) begin
      c[BIT_RIGHT] = 1'b1;
    end
    if (y < bot) begin
      c[BIT_BOTTOM] = 1'b1;
    end else if (y > tp) begin
      c[BIT_TOP] = 1'b1;
    end
    return c;
  endfunction

endpackage

[hdl/lco_front.sv]
// lco_front: takes requests, computes both endpoint outcodes and holds them
// in a two-entry queue for the back end. Depends on lco_pkg.
module lco_front import lco_pkg::*; #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ENTRY_BITS = 4 * 16 + 32 + 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [31:0]                  pen_colour,
  input  logic signed [COORD_BITS-1:0] clip_left,
  input  logic signed [COORD_BITS-1:0] clip_right,
  input  logic signed [COORD_BITS-1:0] clip_bottom,
  input  logic signed [COORD_BITS-1:0] clip_top,
  output logic                         q_valid,
  output logic [ENTRY_BITS-1:0]        q_data,
  input  logic                         q_pop
);

  logic [ENTRY_BITS-1:0] slot [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic [3:0]            c0;
  logic [3:0]            c1;
  logic                  push;

  assign c0 = outcode(32'(start_x), 32'(start_y), 32'(clip_left), 32'(clip_right),
                      32'(clip_bottom), 32'(clip_top));
  assign c1 = outcode(32'(end_x), 32'(end_y), 32'(clip_left), 32'(clip_right),
                      32'(clip_bottom), 32'(clip_top));

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {start_x, start_y, end_x, end_y, pen_colour, c0, c1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[hdl/lco_div.sv]
// lco_div: unsigned restoring divider, two quotient bits per cycle.
// No package dependencies.
module lco_div #(
  parameter int unsigned NUM_BITS = 34,
  parameter int unsigned DEN_BITS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                busy,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int unsigned STEPS = (NUM_BITS + 1) / 2;
  localparam int unsigned PADW  = 2 * STEPS;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [PADW-1:0]     num_sh;
  logic [PADW-1:0]     quo;
  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS-1:0] den;
  logic [CW-1:0]       cnt;
  logic [PADW-1:0]     num_sh_next;
  logic [PADW-1:0]     quo_next;
  logic [DEN_BITS:0]   rem_next;

  always_comb begin
    num_sh_next = num_sh;
    quo_next    = quo;
    rem_next    = rem;
    for (int i = 0; i < 2; i++) begin
      rem_next    = {rem_next[DEN_BITS-1:0], num_sh_next[PADW-1]};
      num_sh_next = {num_sh_next[PADW-2:0], 1'b0};
      if (rem_next >= {1'b0, den}) begin
        rem_next = rem_next - {1'b0, den};
        quo_next = {quo_next[PADW-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[PADW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo[NUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= PADW'(dividend);
      quo    <= '0;
      rem    <= '0;
      den    <= divisor;
    end else if (busy) begin
      num_sh <= num_sh_next;
      quo    <= quo_next;
      rem    <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[hdl/lco_back.sv]
// lco_back: clip engine. One pass per edge crossing: multiply, divide,
// add with saturation, new outcode. Depends on lco_pkg and lco_div.
module lco_back import lco_pkg::*; #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ENTRY_BITS = 4 * 16 + 32 + 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [ENTRY_BITS-1:0]        q_data,
  output logic                         q_pop,
  input  logic signed [COORD_BITS-1:0] clip_left,
  input  logic signed [COORD_BITS-1:0] clip_right,
  input  logic signed [COORD_BITS-1:0] clip_bottom,
  input  logic signed [COORD_BITS-1:0] clip_top,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted,
  output logic signed [COORD_BITS-1:0] clipped_start_x,
  output logic signed [COORD_BITS-1:0] clipped_start_y,
  output logic signed [COORD_BITS-1:0] clipped_end_x,
  output logic signed [COORD_BITS-1:0] clipped_end_y,
  output logic [31:0]                  line_colour
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = CB + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned SW = PW + 2;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}};

  back_state_t state, state_next;
  back_ctrl_t  ctl;

  logic signed [CB-1:0] x0, y0, x1, y1;
  logic [3:0]           c0, c1;
  logic [31:0]          colour;
  logic [2:0]           pass;

  logic signed [CB-1:0] base;
  logic signed [EW-1:0] span, num, den;
  logic signed [CB-1:0] fix;
  logic                 fix_is_y;
  logic                 neg;
  logic                 den_zero;
  logic                 div_busy;
  logic [PW-1:0]        quo;

  logic                 done, is_accept, out_free;
  logic [3:0]           co;
  logic signed [CB-1:0] e_base, e_fix;
  logic signed [EW-1:0] e_span, e_num, e_den;
  logic                 e_is_y;
  logic [PW-1:0]        prod_mag;
  logic [EW-1:0]        den_mag;
  logic signed [SW-1:0] qs, sum;
  logic signed [CB-1:0] res;
  logic signed [CB-1:0] px, py;
  logic [3:0]           pc;

  assign is_accept = ((c0 | c1) == 4'd0);
  assign done      = is_accept || ((c0 & c1) != 4'd0) || (pass == MAX_PASSES);
  assign out_free  = !out_valid || out_ready;
  assign co        = (c0 != 4'd0) ? c0 : c1;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (!done) begin
          state_next = ST_MUL;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   if (!div_busy) state_next = ST_ADD;
      ST_ADD:   state_next = ST_CODE;
      ST_CODE:  state_next = ST_CHECK;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE:  ctl.pop = q_valid;
      ST_CHECK: begin
        ctl.load_edge = !done;
        ctl.load_out  = done && out_free;
      end
      ST_MUL:   begin
        ctl.load_prod = 1'b1;
        ctl.div_start = 1'b1;
      end
      ST_DIV:   ctl = '0;
      ST_ADD:   ctl.write_point = 1'b1;
      ST_CODE:  ctl.write_code = 1'b1;
      default:  ctl = '0;
    endcase
  end

  assign q_pop = ctl.pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // edge choice: top, bottom, right, left
  always_comb begin
    if (co[BIT_TOP] || co[BIT_BOTTOM]) begin
      e_fix  = co[BIT_TOP] ? clip_top : clip_bottom;
      e_base = x0;
      e_span = EW'(x1) - EW'(x0);
      e_num  = EW'(e_fix) - EW'(y0);
      e_den  = EW'(y1) - EW'(y0);
      e_is_y = 1'b1;
    end else begin
      e_fix  = co[BIT_RIGHT] ? clip_right : clip_left;
      e_base = y0;
      e_span = EW'(y1) - EW'(y0);
      e_num  = EW'(e_fix) - EW'(x0);
      e_den  = EW'(x1) - EW'(x0);
      e_is_y = 1'b0;
    end
  end

  assign den_mag = den[EW-1] ? EW'(-den) : EW'(den);

  lco_div #(.NUM_BITS(PW), .DEN_BITS(EW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (prod_mag),
    .divisor  (den_mag),
    .busy     (div_busy),
    .quotient (quo)
  );

  // quotient rounds toward zero: divide magnitudes, then apply the sign
  always_comb begin
    prod_mag = (span[EW-1] ^ num[EW-1]) ? PW'(-(PW'(span) * PW'(num)))
                                        : PW'(PW'(span) * PW'(num));
    qs       = neg ? -SW'({1'b0, quo}) : SW'({1'b0, quo});
    sum      = SW'(base) + qs;
    if (den_zero) begin
      res = base;
    end else if (sum > SAT_HI) begin
      res = SAT_HI[CB-1:0];
    end else if (sum < SAT_LO) begin
      res = SAT_LO[CB-1:0];
    end else begin
      res = sum[CB-1:0];
    end
  end

  assign px = (c0 != 4'd0) ? x0 : x1;
  assign py = (c0 != 4'd0) ? y0 : y1;
  assign pc = outcode(32'(px), 32'(py), 32'(clip_left), 32'(clip_right),
                      32'(clip_bottom), 32'(clip_top));

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      {x0, y0, x1, y1, colour, c0, c1} <= q_data;
      pass <= 3'd0;
    end
    if (ctl.load_edge) begin
      base     <= e_base;
      span     <= e_span;
      num      <= e_num;
      den      <= e_den;
      fix      <= e_fix;
      fix_is_y <= e_is_y;
    end
    if (ctl.load_prod) begin
      neg      <= span[EW-1] ^ num[EW-1] ^ den[EW-1];
      den_zero <= (den == '0);
    end
    if (ctl.write_point) begin
      if (c0 != 4'd0) begin
        x0 <= fix_is_y ? res : fix;
        y0 <= fix_is_y ? fix : res;
      end else begin
        x1 <= fix_is_y ? res : fix;
        y1 <= fix_is_y ? fix : res;
      end
    end
    if (ctl.write_code) begin
      if (c0 != 4'd0) begin
        c0 <= pc;
      end else begin
        c1 <= pc;
      end
      pass <= pass + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      accepted        <= is_accept;
      clipped_start_x <= is_accept ? x0 : '0;
      clipped_start_y <= is_accept ? y0 : '0;
      clipped_end_x   <= is_accept ? x1 : '0;
      clipped_end_y   <= is_accept ? y1 : '0;
      line_colour     <= colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hdl/line_clip_outcode.sv]
// line_clip_outcode: top level of the outcode line clipper.
// Depends on lco_pkg, lco_front, lco_div and lco_back.
//
//  channel   direction  handshake              payload
//  in        request    in_valid / in_ready    start_x start_y end_x end_y pen_colour
//  out       result     out_valid / out_ready  accepted clipped_* line_colour
//  cfg       write      cfg_we                 cfg_index cfg_data
//
// One request ends in ST_CHECK when accepted or rejected on its first outcodes;
// otherwise each clip pass runs ST_MUL, ST_DIV, ST_ADD and ST_CODE, at most four
// passes. The pass time is set by the two-bit-per-cycle divider.
// The two-entry front queue keeps taking requests, until it is full, while the
// engine works or the output register waits on out_ready. Synchronous reset
// loads the window 0..639 by 0..479 and empties the queue and output register.
module line_clip_outcode import lco_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [31:0]                  pen_colour,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted,
  output logic signed [COORD_BITS-1:0] clipped_start_x,
  output logic signed [COORD_BITS-1:0] clipped_start_y,
  output logic signed [COORD_BITS-1:0] clipped_end_x,
  output logic signed [COORD_BITS-1:0] clipped_end_y,
  output logic [31:0]                  line_colour
);

  // queue entry: four coordinates, colour, two outcodes
  localparam int unsigned ENTRY_BITS = 4 * COORD_BITS + 32 + 8;

  logic signed [COORD_BITS-1:0] clip_left, clip_right, clip_bottom, clip_top;
  logic                         q_valid;
  logic                         q_pop;
  logic [ENTRY_BITS-1:0]        q_data;

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= COORD_BITS'(0);
      clip_right  <= COORD_BITS'(639);
      clip_bottom <= COORD_BITS'(0);
      clip_top    <= COORD_BITS'(479);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   clip_left   <= cfg_data;
        REG_RIGHT:  clip_right  <= cfg_data;
        REG_BOTTOM: clip_bottom <= cfg_data;
        REG_TOP:    clip_top    <= cfg_data;
        default:    clip_left   <= clip_left;
      endcase
    end
  end

  lco_front #(.COORD_BITS(COORD_BITS), .ENTRY_BITS(ENTRY_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .pen_colour  (pen_colour),
    .clip_left   (clip_left),
    .clip_right  (clip_right),
    .clip_bottom (clip_bottom),
    .clip_top    (clip_top),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop)
  );

  lco_back #(.COORD_BITS(COORD_BITS), .ENTRY_BITS(ENTRY_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .clip_left       (clip_left),
    .clip_right      (clip_right),
    .clip_bottom     (clip_bottom),
    .clip_top        (clip_top),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .clipped_start_x (clipped_start_x),
    .clipped_start_y (clipped_start_y),
    .clipped_end_x   (clipped_end_x),
    .clipped_end_y   (clipped_end_y),
    .line_colour     (line_colour)
  );

endmodule

[hdl/lco_checker.sv]
// lco_checker: port-level checks on line_clip_outcode, bound to the top.
// Depends on lco_pkg.
module lco_checker import lco_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_we,
  input logic [1:0]                   cfg_index,
  input logic [COORD_BITS-1:0]        cfg_data,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         accepted,
  input logic signed [COORD_BITS-1:0] clipped_start_x,
  input logic signed [COORD_BITS-1:0] clipped_start_y,
  input logic signed [COORD_BITS-1:0] clipped_end_x,
  input logic signed [COORD_BITS-1:0] clipped_end_y,
  input logic [31:0]                  line_colour
);

  logic signed [COORD_BITS-1:0] lft, rgt, bot, tp;

  // shadow of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      lft <= COORD_BITS'(0);
      rgt <= COORD_BITS'(639);
      bot <= COORD_BITS'(0);
      tp  <= COORD_BITS'(479);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   lft <= cfg_data;
        REG_RIGHT:  rgt <= cfg_data;
        REG_BOTTOM: bot <= cfg_data;
        REG_TOP:    tp  <= cfg_data;
        default:    lft <= lft;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(line_colour)
      && $stable(clipped_start_x) && $stable(clipped_end_y))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> clipped_start_x == '0 && clipped_start_y == '0
      && clipped_end_x == '0 && clipped_end_y == '0)
    else $error("rejected segment carries coordinates");

  a_accept_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> clipped_start_x >= lft && clipped_start_x <= rgt
      && clipped_end_x >= lft && clipped_end_x <= rgt
      && clipped_start_y >= bot && clipped_start_y <= tp
      && clipped_end_y >= bot && clipped_end_y <= tp)
    else $error("accepted endpoint outside window");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_in_ready_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind line_clip_outcode lco_checker #(.COORD_BITS(COORD_BITS)) u_lco_checker (.*);

[tb/sv/lco_checker.sv]
// tb_lco_checker: watches the request, result and configuration ports of the
// line clipper, predicts each clipped segment and compares. Depends on lco_pkg.
module tb_lco_checker import lco_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [31:0]                  pen_colour,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         accepted,
  input  logic signed [COORD_BITS-1:0] clipped_start_x,
  input  logic signed [COORD_BITS-1:0] clipped_start_y,
  input  logic signed [COORD_BITS-1:0] clipped_end_x,
  input  logic signed [COORD_BITS-1:0] clipped_end_y,
  input  logic [31:0]                  line_colour,
  output int                           errors,
  output int                           pending
);

  typedef struct packed {
    logic                         acc;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic [31:0]                  col;
  } seg_t;

  seg_t segs_due[$];
  longint win_l, win_r, win_b, win_t;

  localparam longint CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  function automatic longint clamp(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic logic [3:0] zone(longint x, longint y);
    logic [3:0] c;
    c = 4'd0;
    if (x < win_l) c[BIT_LEFT] = 1'b1;
    else if (x > win_r) c[BIT_RIGHT] = 1'b1;
    if (y < win_b) c[BIT_BOTTOM] = 1'b1;
    else if (y > win_t) c[BIT_TOP] = 1'b1;
    return c;
  endfunction

  // SV '/' on longint truncates toward zero, as required
  function automatic longint lerp(longint a, longint span, longint num, longint den);
    if (den == 0) return clamp(a);
    return clamp(a + (span * num) / den);
  endfunction

  function automatic seg_t clip_segment(longint x0, longint y0, longint x1,
                                        longint y1, logic [31:0] col);
    seg_t r;
    logic [3:0] c0, c1, co;
    longint nx, ny;
    bit ok;
    ok = 1'b0;
    c0 = zone(x0, y0);
    c1 = zone(x1, y1);
    for (int p = 0; p <= 4; p++) begin
      if ((c0 | c1) == 4'd0) begin
        ok = 1'b1;
        break;
      end
      if ((c0 & c1) != 4'd0 || p == 4) break;
      co = (c0 != 0) ? c0 : c1;
      if (co[BIT_TOP]) begin
        nx = lerp(x0, x1 - x0, win_t - y0, y1 - y0); ny = win_t;
      end else if (co[BIT_BOTTOM]) begin
        nx = lerp(x0, x1 - x0, win_b - y0, y1 - y0); ny = win_b;
      end else if (co[BIT_RIGHT]) begin
        ny = lerp(y0, y1 - y0, win_r - x0, x1 - x0); nx = win_r;
      end else begin
        ny = lerp(y0, y1 - y0, win_l - x0, x1 - x0); nx = win_l;
      end
      if (c0 != 0) begin
        x0 = nx; y0 = ny; c0 = zone(x0, y0);
      end else begin
        x1 = nx; y1 = ny; c1 = zone(x1, y1);
      end
    end
    r.acc = ok;
    r.sx = ok ? x0[COORD_BITS-1:0] : '0;
    r.sy = ok ? y0[COORD_BITS-1:0] : '0;
    r.ex = ok ? x1[COORD_BITS-1:0] : '0;
    r.ey = ok ? y1[COORD_BITS-1:0] : '0;
    r.col = col;
    return r;
  endfunction

  initial errors = 0;
  initial pending = 0;

  always @(posedge clk) begin
    seg_t got, want;
    if (rst) begin
      win_l <= 0; win_r <= 639; win_b <= 0; win_t <= 479;
      segs_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT:   win_l <= longint'(signed'(cfg_data));
          REG_RIGHT:  win_r <= longint'(signed'(cfg_data));
          REG_BOTTOM: win_b <= longint'(signed'(cfg_data));
          default:    win_t <= longint'(signed'(cfg_data));
        endcase
      end
      if (in_valid && in_ready)
        segs_due.push_back(clip_segment(start_x, start_y, end_x, end_y, pen_colour));
      if (out_valid && out_ready) begin
        got = '{accepted, clipped_start_x, clipped_start_y, clipped_end_x,
                clipped_end_y, line_colour};
        if (segs_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = segs_due.pop_front();
          if (got.acc !== want.acc) begin
            errors++;
            $display("%0t: accepted exp %0d got %0d", $time, want.acc, got.acc);
          end
          if (got.sx !== want.sx) begin
            errors++;
            $display("%0t: start_x exp %0d got %0d", $time, want.sx, got.sx);
          end
          if (got.sy !== want.sy) begin
            errors++;
            $display("%0t: start_y exp %0d got %0d", $time, want.sy, got.sy);
          end
          if (got.ex !== want.ex) begin
            errors++;
            $display("%0t: end_x exp %0d got %0d", $time, want.ex, got.ex);
          end
          if (got.ey !== want.ey) begin
            errors++;
            $display("%0t: end_y exp %0d got %0d", $time, want.ey, got.ey);
          end
          if (got.col !== want.col) begin
            errors++;
            $display("%0t: colour exp %h got %h", $time, want.col, got.col);
          end
        end
      end
    end
    pending <= segs_due.size();
  end

endmodule

[tb/sv/tb_line_clip_outcode.sv]
// tb_line_clip_outcode: stimulus and verdict for the line clipper.
// Depends on lco_pkg, line_clip_outcode and tb_lco_checker.
module tb_line_clip_outcode;
  import lco_pkg::*;

  localparam int CB = 16;
  // watchdog: the limit covers the worst request plus the longest input gap, two queued ahead
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0, rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_LEFT;
  logic [CB-1:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [31:0] pen_colour = '0;
  logic out_valid, out_ready = 1'b0, accepted;
  logic signed [CB-1:0] clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;
  logic [31:0] line_colour;
  int errors, pending, idle_cycles;
  bit drain_quiet;  // when set, the result side never stalls

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  line_clip_outcode #(.COORD_BITS(CB)) u_dut (.*);

  tb_lco_checker #(.COORD_BITS(CB)) u_chk (.*);

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_line_clip_outcode: done, errors");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // result side: random stall before each result is taken
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = drain_quiet ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13));
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // valid stays up after acceptance until the next request or a gap drops it
  task automatic send_seg(int x0, int y0, int x1, int y1, logic [31:0] col, bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 13);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1'b1;
    start_x <= CB'(x0); start_y <= CB'(y0); end_x <= CB'(x1); end_y <= CB'(y1);
    pen_colour <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // write only while idle: queue empty plus the worst request time
  task automatic set_window(int l, int r, int b, int t);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LEFT;   cfg_data <= l[CB-1:0]; @(negedge clk);
    cfg_index <= REG_RIGHT;  cfg_data <= r[CB-1:0]; @(negedge clk);
    cfg_index <= REG_BOTTOM; cfg_data <= b[CB-1:0]; @(negedge clk);
    cfg_index <= REG_TOP;    cfg_data <= t[CB-1:0]; @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // coordinate within the window span most of the time, otherwise near an edge or anywhere
  function automatic int pick(int lo, int hi);
    int m;
    m = $urandom_range(0, 9);
    if (m < 2) return int'($urandom());
    if (m < 4) return (($urandom_range(0, 1)) ? lo : hi) + int'($urandom_range(0, 6)) - 3;
    return lo + int'($urandom_range(0, 40)) - 20
           + int'($urandom_range(0, 1000)) * (hi - lo) / 1000;
  endfunction

  task automatic random_phase(int n, int l, int r, int b, int t);
    bit burst;
    for (int i = 0; i < n; i++) begin
      burst = ($urandom_range(0, 7) == 0);
      send_seg(pick(l, r), pick(b, t), pick(l, r), pick(b, t), $urandom(), burst);
    end
  endtask

  initial begin
    int w[4][4];
    drain_quiet = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed, reset window 0..639 x 0..479
    send_seg(10, 10, 600, 400, 32'h0, 0);                // both inside
    send_seg(-100, -100, -10, -50, 32'hFFFF_FFFF, 0);   // shared zone, reject
    send_seg(-100, 240, 800, 240, 32'hA5A5_5A5A, 0);    // across left and right
    send_seg(320, -50, 320, 600, 32'h1234_5678, 0);     // across bottom and top
    send_seg(-200, -200, 900, 700, 32'h8000_0001, 0);   // diagonal, several passes
    send_seg(-1000, 100, 100, -1000, 32'h0F0F_0F0F, 0); // misses corner
    send_seg(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 32'h5555_AAAA, 0);
    send_seg(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 32'hAAAA_5555, 1);
    send_seg(0, 0, 639, 479, 32'h1, 1);                 // window corners
    send_seg(640, 480, 640, 480, 32'h2, 0);
    send_seg(-1, 500, 700, -1, 32'h3, 0);

    // extremes: full-range window, then inverted ones
    set_window(-32768, 32767, -32768, 32767);
    send_seg(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 32'hDEAD_BEEF, 0);
    send_seg(16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 32'hBEEF_DEAD, 0);
    set_window(32767, -32768, 32767, -32768);
    send_seg(0, 0, 100, 100, 32'h7, 0);
    send_seg(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 32'h8, 0);
    set_window(100, -100, -50, 50);
    send_seg(-200, 0, 200, 10, 32'h9, 0);
    send_seg(0, -80, 5, 80, 32'hA, 0);

    w = '{'{0, 639, 0, 479}, '{-32768, 32767, -32768, 32767},
          '{-500, 500, -300, 300}, '{200, -200, 100, -100}};
    for (int ph = 0; ph < 8; ph++) begin
      int k;
      k = ph % 4;
      set_window(w[k][0], w[k][1], w[k][2], w[k][3]);
      random_phase((k == 3) ? 60 : 200, w[k][0], w[k][1], w[k][2], w[k][3]);
    end
    // random windows too
    for (int ph = 0; ph < 3; ph++) begin
      int a, b2, c, d;
      a = int'($urandom_range(0, 2000)) - 1000; b2 = a + $urandom_range(0, 500);
      c = int'($urandom_range(0, 2000)) - 1000; d = c + $urandom_range(0, 500);
      set_window(a, b2, c, d);
      random_phase(100, a, b2, c, d);
    end

    in_valid <= 1'b0;
    drain_quiet = 1'b1;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0)
      $display("tb_line_clip_outcode: done, clean");
    else
      $display("tb_line_clip_outcode: done, errors");
    $finish;
  end

endmodule

[files.f]
hdl/lco_pkg.sv
hdl/lco_front.sv
hdl/lco_div.sv
hdl/lco_back.sv
hdl/line_clip_outcode.sv
hdl/lco_checker.sv
tb/sv/lco_checker.sv
tb/sv/tb_line_clip_outcode.sv
